@@ rtl/core/mawc_pkg.sv @@
// Shared types and constants for the moving-average wave counter.
package mawc_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_WAVE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_BAND_LOW       = 2'd1;
    localparam logic [1:0] REG_BAND_HIGH      = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] THRESHOLD_RESET = 16'd9;
    localparam logic [14:0] BAND_LOW_RESET  = 15'd5;
    localparam logic [14:0] BAND_HIGH_RESET = 15'd10;

    // Result queue depth; it also bounds the items in flight.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // One result item.
    typedef struct packed {
        logic signed [15:0] average;
        logic [15:0]        half_waves;
        logic [14:0]        full_waves;
        logic               rising;
        logic               motor_on;
    } result_t;

endpackage

@@ rtl/core/moving_average_wave_counter_top.sv @@
// Top level of the moving-average wave counter: sample ring, divider and wave tracking.
//
//  Channel   Signals                                   Direction  Handshake
//  sample    sample_valid, sample_stall, sample        in         valid / stall
//  result    result_valid, result_stall, average,      out        valid / stall
//            half_waves, full_waves, rising, motor_on
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         valid / ready
//
// One item is accepted per cycle while sample_stall is low.
// The sample ring lives in a RAM that is read and written at the same entry in the
// accept cycle; a fill flag makes unwritten entries read as zero, so no clearing pass.
// sample_stall rises when 8 items are outstanding, the size of the result queue.
// result_stall only holds the queue; the pipeline itself never stops.
module moving_average_wave_counter_top
    import mawc_pkg::*;
#(
    parameter int WINDOW = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  logic signed [15:0] sample,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] average,
    output logic [15:0]        half_waves,
    output logic [14:0]        full_waves,
    output logic               rising,
    output logic               motor_on,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 16 + $clog2(WINDOW);
    localparam int DIV_K  = SUM_W + $clog2(WINDOW);
    localparam int PROD_W = SUM_W + DIV_K;
    localparam logic [DIV_K-1:0] RECIP =
        DIV_K'(((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Configuration registers.
    logic [15:0] threshold_reg;
    logic [14:0] band_low_reg;
    logic [14:0] band_high_reg;

    // Input side control.
    logic                  accept;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic [FIFO_CNT_W-1:0] credit_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic                  filled_reg;
    logic                  filled_next;

    // Pipeline valids.
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic s5_valid_reg;
    logic s6_valid_reg;

    // Pipeline payload.
    logic signed [15:0]      s1_sample_reg;
    logic                    s1_empty_reg;
    logic [15:0]             ring_rdata;
    logic signed [15:0]      old_sample;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0]        s3_mag_reg;
    logic                    s3_neg_reg;
    logic [PROD_W-1:0]       s4_prod_reg;
    logic                    s4_neg_reg;
    logic [15:0]             quotient;
    logic signed [15:0]      s5_avg_reg;

    // Wave tracking state.
    logic               seen_first_reg;
    logic               rising_reg;
    logic               rising_next;
    logic signed [15:0] peak_reg;
    logic signed [15:0] peak_next;
    logic signed [15:0] valley_reg;
    logic signed [15:0] valley_next;
    logic signed [15:0] prev_avg_reg;
    logic [15:0]        half_count_reg;
    logic [15:0]        half_count_next;
    logic signed [16:0] swing;
    logic               turn;
    logic               big_swing;

    // Result assembly.
    result_t push_data;
    result_t pop_data;
    logic    not_empty;

    assign cfg_ready    = 1'b1;
    assign sample_stall = (credit_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign accept       = sample_valid && !sample_stall;
    assign pop          = not_empty && !result_stall;
    assign result_valid = not_empty;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            band_low_reg  <= BAND_LOW_RESET;
            band_high_reg <= BAND_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAVE_THRESHOLD: threshold_reg <= cfg_data;
                REG_BAND_LOW:       band_low_reg  <= cfg_data[14:0];
                REG_BAND_HIGH:      band_high_reg <= cfg_data[14:0];
                default:            threshold_reg <= threshold_reg;
            endcase
        end
    end

    // Outstanding item count, ring pointer and fill flag.
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            credit_next = credit_reg - 1'b1;
        end
        idx_next    = idx_reg;
        filled_next = filled_reg;
        if (accept)
        begin
            if (idx_reg == IDX_W'(WINDOW - 1))
            begin
                idx_next    = '0;
                filled_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    // Sample ring: the old entry is read while the new sample is written.
    mawc_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (idx_reg),
        .wdata (sample),
        .raddr (idx_reg),
        .rdata (ring_rdata)
    );

    // Running sum: add the new sample, drop the one leaving the window.
    assign old_sample = s1_empty_reg ? 16'sd0 : $signed(ring_rdata);
    assign sum_next   = sum_reg + SUM_W'(s1_sample_reg) - SUM_W'(old_sample);

    // Divide by WINDOW on the magnitude with a reciprocal, truncating toward zero.
    assign quotient = s4_prod_reg[DIV_K +: 16];

    // Direction tracking and half-wave counting.
    assign swing     = 17'(peak_reg) - 17'(valley_reg);
    assign big_swing = ($signed({swing[16], swing}) > $signed({2'b00, threshold_reg}));

    always_comb
    begin
        rising_next = rising_reg;
        peak_next   = peak_reg;
        valley_next = valley_reg;
        turn        = 1'b0;
        if (!seen_first_reg)
        begin
            rising_next = 1'b1;
            peak_next   = s5_avg_reg;
        end
        else if (s5_avg_reg > prev_avg_reg)
        begin
            rising_next = 1'b1;
            turn        = !rising_reg;
            peak_next   = s5_avg_reg;
        end
        else if (s5_avg_reg < prev_avg_reg)
        begin
            rising_next = 1'b0;
            turn        = rising_reg;
            valley_next = s5_avg_reg;
        end
        half_count_next = half_count_reg;
        if (turn && big_swing && (half_count_reg != 16'hFFFF))
        begin
            half_count_next = half_count_reg + 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg     <= '0;
            idx_reg        <= '0;
            filled_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            s6_valid_reg   <= 1'b0;
            sum_reg        <= '0;
            seen_first_reg <= 1'b0;
            rising_reg     <= 1'b1;
            peak_reg       <= '0;
            valley_reg     <= '0;
            prev_avg_reg   <= '0;
            half_count_reg <= '0;
        end
        else
        begin
            credit_reg   <= credit_next;
            idx_reg      <= idx_next;
            filled_reg   <= filled_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            if (s1_valid_reg)
            begin
                sum_reg <= sum_next;
            end
            if (s5_valid_reg)
            begin
                seen_first_reg <= 1'b1;
                rising_reg     <= rising_next;
                peak_reg       <= peak_next;
                valley_reg     <= valley_next;
                prev_avg_reg   <= s5_avg_reg;
                half_count_reg <= half_count_next;
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        s1_sample_reg <= sample;
        s1_empty_reg  <= !filled_reg;
        s3_neg_reg    <= sum_reg[SUM_W-1];
        s3_mag_reg    <= sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        s4_neg_reg    <= s3_neg_reg;
        s4_prod_reg   <= PROD_W'(s3_mag_reg) * PROD_W'(RECIP);
        s5_avg_reg    <= s4_neg_reg ? $signed(-quotient) : $signed(quotient);
    end

    // Result built from the freshly updated state.
    always_comb
    begin
        push_data.average    = prev_avg_reg;
        push_data.half_waves = half_count_reg;
        push_data.full_waves = half_count_reg[15:1];
        push_data.rising     = rising_reg;
        push_data.motor_on   = (half_count_reg[15:1] > band_low_reg) &&
                               (half_count_reg[15:1] < band_high_reg);
    end

    mawc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s6_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .not_empty (not_empty)
    );

    assign average    = pop_data.average;
    assign half_waves = pop_data.half_waves;
    assign full_waves = pop_data.full_waves;
    assign rising     = pop_data.rising;
    assign motor_on   = pop_data.motor_on;

endmodule

@@ rtl/core/mawc_ram.sv @@
// Generic single-port-write, registered-read RAM (read returns the old data on a collision).
module mawc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/mawc_fifo.sv @@
// Result queue that decouples the pipeline from the output handshake.
module mawc_fifo
    import mawc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output result_t pop_data,
    output logic    not_empty
);

    result_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    // Pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule
